// ----- src/gaps_pkg.sv -----
// Grid path search package: command, status, direction, config codes, payload and control types.
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

  localparam int SEQ_W = 13;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NOPATH = 2'd1;
  localparam logic [1:0] STS_RANGE  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic       blocked;
    logic [4:0] goal_row;
    logic [4:0] goal_col;
    logic [9:0] step_index;
  } gaps_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] path_cost;
    logic [4:0] path_row;
    logic [4:0] path_col;
  } gaps_out_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } heap_req_t;

  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } heap_sts_t;

endpackage
`default_nettype wire

// ----- src/grid_astar_path_search_unit.sv -----
// Grid path search unit: command decode, cell and path stores, search sequencer.
// Cell write, path read and unused commands: result the cycle after acceptance, one per cycle.
// Search: a closed-mark sweep over every cell, then heap pushes and pops (HEAP_DEPTH 4096,
// one heap memory) with sequencing around each; a found path is traced back one step at a time.
// Reset: a sweep over every cell clears obstacle and closed marks with busy high. Results last
// one cycle; no receiver stall.
`timescale 1ns / 1ps
`default_nettype none
module grid_astar_path_search_unit
  import gaps_pkg::*;
#(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int HEAP_DEPTH = 4096
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       start,
  output logic      busy,
  input  gaps_in_t  in_data,
  output logic      out_valid,
  output gaps_out_t out_data,
  input  wire       cfg_we,
  input  wire       cfg_index,
  input  wire [5:0] cfg_wdata
);

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int AW     = RW + CW;
  localparam int CELLS  = 1 << AW;
  localparam int GW     = AW + 1;
  localparam int FW     = AW + 2;
  localparam int KEY_W  = FW + SEQ_W;
  localparam int DATA_W = GW + AW + 2;
  localparam int EW     = KEY_W + DATA_W;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_SCLR  = 12'b000000000100,
    S_SPUSH = 12'b000000001000,
    S_POP   = 12'b000000010000,
    S_POPW  = 12'b000000100000,
    S_CHK   = 12'b000001000000,
    S_NB    = 12'b000010000000,
    S_NBW   = 12'b000100000000,
    S_PUSHW = 12'b001000000000,
    S_TRACE = 12'b010000000000,
    S_TRW   = 12'b100000000000
  } srch_state_t;

  srch_state_t state_r, state_nxt;

  logic [5:0]        grid_rows_r, grid_cols_r;
  logic [8:0]        act_rows, act_cols;

  logic              obst_mem [CELLS];
  logic [2:0]        cl_mem   [CELLS];
  logic [AW-1:0]     path_mem [CELLS];

  logic              obst_we, obst_wd, obst_rd_r;
  logic [AW-1:0]     obst_wa, obst_ra;
  logic              cl_we;
  logic [2:0]        cl_wd, cl_rd_r;
  logic [AW-1:0]     cl_wa, cl_ra;
  logic              path_we, path_re;
  logic [AW-1:0]     path_wa, path_ra, path_rd_r;

  logic [AW-1:0]     clr_cnt_r;
  logic              clr_last;

  logic [RW-1:0]     start_r_r, goal_r_r;
  logic [CW-1:0]     start_c_r, goal_c_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [EW-1:0]     cur_r;
  logic [1:0]        d_r;
  logic [AW-1:0]     nb_r;
  logic [GW-1:0]     k_r;
  logic [AW-1:0]     tcell_r;

  logic              out_valid_r, out_sel_r, path_valid_r;
  logic [1:0]        out_status_r;
  logic [9:0]        found_cost_r;

  heap_req_t         heap_req;
  heap_sts_t         heap_sts;
  logic [EW-1:0]     heap_push_entry, heap_top;

  logic              accept;
  logic              in_cell_ok, in_goal_ok;
  logic [GW-1:0]     cur_g;
  logic [AW-1:0]     cur_cell;
  logic [1:0]        cur_dir;
  logic [RW-1:0]     cur_row, nb_row, tr_row;
  logic [CW-1:0]     cur_col, nb_col, tr_col;
  logic              nb_ok;
  logic [RW-1:0]     h_start_r, h_nb_r;
  logic [CW-1:0]     h_start_c, h_nb_c;
  logic [FW-1:0]     f_start, f_nb;
  logic              is_goal;

  always_comb begin
    act_rows = ({3'b0, grid_rows_r} < 9'(MAX_ROWS)) ? {3'b0, grid_rows_r} : 9'(MAX_ROWS);
    act_cols = ({3'b0, grid_cols_r} < 9'(MAX_COLS)) ? {3'b0, grid_cols_r} : 9'(MAX_COLS);
  end

  assign accept     = start && !busy;
  assign in_cell_ok = ({4'b0, in_data.cell_row} < act_rows) && ({4'b0, in_data.cell_col} < act_cols);
  assign in_goal_ok = ({4'b0, in_data.goal_row} < act_rows) && ({4'b0, in_data.goal_col} < act_cols);
  assign clr_last   = (clr_cnt_r == {AW{1'b1}});

  assign cur_g    = cur_r[DATA_W-1 -: GW];
  assign cur_cell = cur_r[AW+1:2];
  assign cur_dir  = cur_r[1:0];
  assign cur_row  = cur_cell[AW-1:CW];
  assign cur_col  = cur_cell[CW-1:0];
  assign is_goal  = (cur_row == goal_r_r) && (cur_col == goal_c_r);

  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    nb_ok  = 1'b0;
    case (d_r)
      DIR_UP: begin
        nb_row = cur_row - RW'(1);
        nb_ok  = (cur_row != '0);
      end
      DIR_DOWN: begin
        nb_row = cur_row + RW'(1);
        nb_ok  = (9'(cur_row) + 9'd1) < act_rows;
      end
      DIR_LEFT: begin
        nb_col = cur_col - CW'(1);
        nb_ok  = (cur_col != '0);
      end
      DIR_RIGHT: begin
        nb_col = cur_col + CW'(1);
        nb_ok  = (9'(cur_col) + 9'd1) < act_cols;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tr_row = tcell_r[AW-1:CW];
    tr_col = tcell_r[CW-1:0];
    case (cl_rd_r[1:0])
      DIR_UP:    tr_row = tcell_r[AW-1:CW] + RW'(1);
      DIR_DOWN:  tr_row = tcell_r[AW-1:CW] - RW'(1);
      DIR_LEFT:  tr_col = tcell_r[CW-1:0] + CW'(1);
      DIR_RIGHT: tr_col = tcell_r[CW-1:0] - CW'(1);
      default: begin
      end
    endcase
  end

  always_comb begin
    h_start_r = (start_r_r > goal_r_r) ? start_r_r - goal_r_r : goal_r_r - start_r_r;
    h_start_c = (start_c_r > goal_c_r) ? start_c_r - goal_c_r : goal_c_r - start_c_r;
    h_nb_r    = (nb_r[AW-1:CW] > goal_r_r) ? nb_r[AW-1:CW] - goal_r_r : goal_r_r - nb_r[AW-1:CW];
    h_nb_c    = (nb_r[CW-1:0] > goal_c_r) ? nb_r[CW-1:0] - goal_c_r : goal_c_r - nb_r[CW-1:0];
    f_start   = FW'(h_start_r) + FW'(h_start_c);
    f_nb      = FW'(cur_g) + FW'(1) + FW'(h_nb_r) + FW'(h_nb_c);
  end

  always_comb begin
    state_nxt       = state_r;
    heap_req        = '0;
    heap_push_entry = {f_nb, seq_r, cur_g + GW'(1), nb_r, d_r};
    obst_we         = 1'b0;
    obst_wa         = {RW'(in_data.cell_row), CW'(in_data.cell_col)};
    obst_wd         = in_data.blocked;
    obst_ra         = {nb_row, nb_col};
    cl_we           = 1'b0;
    cl_wa           = clr_cnt_r;
    cl_wd           = 3'b000;
    cl_ra           = heap_top[AW+1:2];
    path_we         = 1'b0;
    path_wa         = AW'(k_r);
    path_re         = 1'b0;
    path_ra         = AW'(in_data.step_index);
    case (state_r)
      S_CLR: begin
        obst_we = 1'b1;
        obst_wa = clr_cnt_r;
        obst_wd = 1'b0;
        cl_we   = 1'b1;
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_WRITE: obst_we = in_cell_ok;
            CMD_SEARCH: begin
              if (in_cell_ok && in_goal_ok) begin
                state_nxt = S_SCLR;
              end
            end
            CMD_READ: path_re = 1'b1;
            default: begin
            end
          endcase
        end
      end
      S_SCLR: begin
        cl_we = 1'b1;
        if (clr_last) begin
          heap_req.clear = 1'b1;
          state_nxt      = S_SPUSH;
        end
      end
      S_SPUSH: begin
        heap_req.push   = 1'b1;
        heap_push_entry = {f_start, seq_r, GW'(0), start_r_r, start_c_r, DIR_UP};
        state_nxt       = S_PUSHW;
      end
      S_POP: begin
        if (heap_sts.empty) begin
          state_nxt = S_IDLE;
        end else begin
          heap_req.pop = 1'b1;
          state_nxt    = S_POPW;
        end
      end
      S_POPW: begin
        if (!heap_sts.busy) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cl_rd_r[2]) begin
          state_nxt = S_POP;
        end else begin
          cl_we     = 1'b1;
          cl_wa     = cur_cell;
          cl_wd     = {1'b1, cur_dir};
          state_nxt = is_goal ? S_TRACE : S_NB;
        end
      end
      S_NB: begin
        if (nb_ok) begin
          state_nxt = S_NBW;
        end else begin
          state_nxt = (d_r == DIR_RIGHT) ? S_POP : S_NB;
        end
      end
      S_NBW: begin
        if (obst_rd_r) begin
          state_nxt = (d_r == DIR_RIGHT) ? S_POP : S_NB;
        end else if (heap_sts.full) begin
          state_nxt = S_IDLE;
        end else begin
          heap_req.push = 1'b1;
          state_nxt     = S_PUSHW;
        end
      end
      S_PUSHW: begin
        if (!heap_sts.busy) begin
          if (cur_r == '0 && seq_r == SEQ_W'(1)) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = (d_r == DIR_RIGHT) ? S_POP : S_NB;
          end
        end
      end
      S_TRACE: begin
        path_we = 1'b1;
        cl_ra   = tcell_r;
        state_nxt = (k_r == '0) ? S_IDLE : S_TRW;
      end
      S_TRW: begin
        state_nxt = S_TRACE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (obst_we) begin
      obst_mem[obst_wa] <= obst_wd;
    end
    obst_rd_r <= obst_mem[obst_ra];
    if (cl_we) begin
      cl_mem[cl_wa] <= cl_wd;
    end
    cl_rd_r <= cl_mem[cl_ra];
    if (path_we) begin
      path_mem[path_wa] <= tcell_r;
    end
    if (path_re) begin
      path_rd_r <= path_mem[path_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      grid_rows_r  <= 6'd32;
      grid_cols_r  <= 6'd32;
      out_valid_r  <= 1'b0;
      found_cost_r <= '0;
      path_valid_r <= 1'b0;
      seq_r        <= '0;
      cur_r        <= '0;
      d_r          <= DIR_UP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          grid_rows_r <= cfg_wdata;
        end else begin
          grid_cols_r <= cfg_wdata;
        end
      end
      case (state_r)
        S_CLR, S_SCLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            out_sel_r <= 1'b0;
            case (in_data.command)
              CMD_WRITE: begin
                out_valid_r  <= 1'b1;
                out_status_r <= in_cell_ok ? STS_OK : STS_RANGE;
              end
              CMD_SEARCH: begin
                start_r_r <= RW'(in_data.cell_row);
                start_c_r <= CW'(in_data.cell_col);
                goal_r_r  <= RW'(in_data.goal_row);
                goal_c_r  <= CW'(in_data.goal_col);
                seq_r     <= '0;
                cur_r     <= '0;
                if (!(in_cell_ok && in_goal_ok)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STS_RANGE;
                  path_valid_r <= 1'b0;
                  found_cost_r <= '0;
                end
              end
              CMD_READ: begin
                out_valid_r <= 1'b1;
                if (!path_valid_r || (in_data.step_index > found_cost_r)) begin
                  out_status_r <= STS_NOPATH;
                end else begin
                  out_status_r <= STS_OK;
                  out_sel_r    <= 1'b1;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= STS_OK;
              end
            endcase
          end
        end
        S_SPUSH: begin
          seq_r <= seq_r + SEQ_W'(1);
        end
        S_POP: begin
          if (heap_sts.empty) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STS_NOPATH;
            path_valid_r <= 1'b0;
            found_cost_r <= '0;
          end
        end
        S_POPW: begin
          if (!heap_sts.busy) begin
            cur_r <= heap_top;
          end
        end
        S_CHK: begin
          d_r     <= DIR_UP;
          k_r     <= cur_g;
          tcell_r <= cur_cell;
        end
        S_NB: begin
          nb_r <= {nb_row, nb_col};
          if (!nb_ok) begin
            d_r <= d_r + 2'd1;
          end
        end
        S_NBW: begin
          if (obst_rd_r) begin
            d_r <= d_r + 2'd1;
          end else if (heap_sts.full) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STS_NOPATH;
            path_valid_r <= 1'b0;
            found_cost_r <= '0;
          end else begin
            seq_r <= seq_r + SEQ_W'(1);
          end
        end
        S_PUSHW: begin
          if (!heap_sts.busy && !(cur_r == '0 && seq_r == SEQ_W'(1))) begin
            d_r <= d_r + 2'd1;
          end
        end
        S_TRACE: begin
          if (k_r == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STS_OK;
            path_valid_r <= 1'b1;
            found_cost_r <= 10'(cur_g);
          end
        end
        S_TRW: begin
          tcell_r <= {tr_row, tr_col};
          k_r     <= k_r - GW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  gaps_heap #(
    .DEPTH  (HEAP_DEPTH),
    .KEY_W  (KEY_W),
    .DATA_W (DATA_W)
  ) u_heap (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (heap_req),
    .push_entry (heap_push_entry),
    .sts        (heap_sts),
    .top_entry  (heap_top)
  );

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_data.status    = out_status_r;
  assign out_data.path_cost = found_cost_r;
  assign out_data.path_row  = out_sel_r ? 5'(path_rd_r[AW-1:CW]) : 5'd0;
  assign out_data.path_col  = out_sel_r ? 5'(path_rd_r[CW-1:0]) : 5'd0;

`ifndef ASSERT_OFF
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    heap_req.push |-> !heap_sts.full)
    else $error("heap push while full");

  a_heap_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (heap_req.push || heap_req.pop) |-> !heap_sts.busy)
    else $error("heap transaction issued while heap busy");

  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_WRITE) |=> out_valid)
    else $error("cell write gave no result");
`endif

endmodule
`default_nettype wire

// ----- src/gaps_heap.sv -----
// Binary min-heap over one synchronous memory, sift-up and sift-down sequencer.
`timescale 1ns / 1ps
`default_nettype none
module gaps_heap
  import gaps_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int KEY_W  = 8,
  parameter int DATA_W = 8
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  heap_req_t               req,
  input  wire [KEY_W+DATA_W-1:0]  push_entry,
  output heap_sts_t               sts,
  output logic [KEY_W+DATA_W-1:0] top_entry
);

  localparam int EW   = KEY_W + DATA_W;
  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = IW + 1;
  localparam int LW   = IW + 2;

  typedef enum logic [7:0] {
    H_IDLE    = 8'b00000001,
    H_PU_RD   = 8'b00000010,
    H_PU_CMP  = 8'b00000100,
    H_PO_TOP  = 8'b00001000,
    H_PO_LAST = 8'b00010000,
    H_PO_RL   = 8'b00100000,
    H_PO_RR   = 8'b01000000,
    H_PO_CMP  = 8'b10000000
  } heap_state_t;

  heap_state_t state_r, state_nxt;

  logic [EW-1:0]   heap_mem [DEPTH];
  logic [EW-1:0]   rdata_r;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;

  logic [CNTW-1:0] count_r;
  logic [IW-1:0]   idx_r;
  logic [EW-1:0]   ent_r;
  logic [EW-1:0]   lv_r;
  logic [EW-1:0]   top_r;

  logic [LW-1:0]   l_idx;
  logic [LW-1:0]   r_idx;
  logic [IW-1:0]   par_idx;
  logic            use_r;
  logic [EW-1:0]   mv;
  logic            mv_before;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rdata_r <= heap_mem[rd_addr];
  end

  always_comb begin
    l_idx     = {1'b0, idx_r, 1'b1};
    r_idx     = l_idx + LW'(1);
    par_idx   = IW'((idx_r - IW'(1)) >> 1);
    use_r     = (r_idx < LW'(count_r)) && (rdata_r[EW-1 -: KEY_W] < lv_r[EW-1 -: KEY_W]);
    mv        = use_r ? rdata_r : lv_r;
    mv_before = mv[EW-1 -: KEY_W] < ent_r[EW-1 -: KEY_W];
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = ent_r;
    case (state_r)
      H_IDLE: begin
        if (req.pop) begin
          state_nxt = H_PO_TOP;
        end else if (req.push) begin
          state_nxt = H_PU_RD;
        end
      end
      H_PU_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = par_idx;
          state_nxt = H_PU_CMP;
        end
      end
      H_PU_CMP: begin
        wr_en = 1'b1;
        if (ent_r[EW-1 -: KEY_W] < rdata_r[EW-1 -: KEY_W]) begin
          wr_data   = rdata_r;
          state_nxt = H_PU_RD;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      H_PO_TOP: begin
        if (count_r == '0) begin
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = IW'(count_r);
          state_nxt = H_PO_LAST;
        end
      end
      H_PO_LAST: begin
        state_nxt = H_PO_RL;
      end
      H_PO_RL: begin
        if (l_idx >= LW'(count_r)) begin
          wr_en     = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = IW'(l_idx);
          state_nxt = H_PO_RR;
        end
      end
      H_PO_RR: begin
        rd_addr   = IW'(r_idx);
        state_nxt = H_PO_CMP;
      end
      H_PO_CMP: begin
        wr_en = 1'b1;
        if (mv_before) begin
          wr_data   = mv;
          state_nxt = H_PO_RL;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        H_IDLE: begin
          if (req.pop) begin
            count_r <= count_r - CNTW'(1);
          end else if (req.push) begin
            ent_r   <= push_entry;
            idx_r   <= IW'(count_r);
            count_r <= count_r + CNTW'(1);
          end else if (req.clear) begin
            count_r <= '0;
          end
        end
        H_PU_CMP: begin
          if (ent_r[EW-1 -: KEY_W] < rdata_r[EW-1 -: KEY_W]) begin
            idx_r <= par_idx;
          end
        end
        H_PO_TOP: begin
          top_r <= rdata_r;
          idx_r <= '0;
        end
        H_PO_LAST: begin
          ent_r <= rdata_r;
        end
        H_PO_RR: begin
          lv_r <= rdata_r;
        end
        H_PO_CMP: begin
          if (mv_before) begin
            idx_r <= use_r ? IW'(r_idx) : IW'(l_idx);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.busy  = (state_r != H_IDLE);
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNTW'(DEPTH));
  assign top_entry = top_r;

endmodule
`default_nettype wire
